// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file rms_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, off while reset is low.
`define RMS_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Concurrent check that also holds during reset.
`define RMS_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== sv/rms_pkg.sv =====
// Package for the running median block: default sizes.
// No dependencies.
`default_nettype none

package rms_pkg;

  localparam int unsigned RMS_CAPACITY    = 64;
  localparam int unsigned RMS_SAMPLE_BITS = 16;
  localparam int unsigned RMS_COUNT_BITS  = $clog2(RMS_CAPACITY + 1);

endpackage

`default_nettype wire

// ===== sv/rms_in_if.sv =====
// Sample channel: valid/ready handshake carrying one signed sample per item.
// Depends on rms_pkg.
`default_nettype none

interface rms_in_if
  import rms_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = RMS_SAMPLE_BITS
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ===== sv/rms_out_if.sv =====
// Result channel: valid/ready handshake carrying doubled median, count, reject flag.
// Depends on rms_pkg.
`default_nettype none

interface rms_out_if
  import rms_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = RMS_SAMPLE_BITS,
  parameter int unsigned COUNT_BITS  = RMS_COUNT_BITS
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS:0]   median_doubled;
  logic [COUNT_BITS-1:0]  stored_count;
  logic                   rejected;

  modport source (output valid, output median_doubled, output stored_count,
                  output rejected, input ready);
  modport sink   (input valid, input median_doubled, input stored_count,
                  input rejected, output ready);
endinterface

`default_nettype wire

// ===== sv/rms_cell.sv =====
// One slot of the sorted insertion chain: holds a sample, shifts right on insert.
// Depends on rms_pkg.
`default_nettype none

module rms_cell
  import rms_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = RMS_SAMPLE_BITS,
  parameter int unsigned COUNT_BITS  = RMS_COUNT_BITS,
  parameter int unsigned INDEX       = 0
) (
  input  wire logic                   clk_i,
  input  wire logic                   ins_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  input  wire logic [COUNT_BITS-1:0]  count_i,
  input  wire logic                   left_lt_i,
  input  wire logic [SAMPLE_BITS-1:0] left_val_i,
  output logic                        lt_o,
  output logic [SAMPLE_BITS-1:0]      val_o,
  output logic [SAMPLE_BITS-1:0]      lo_tap_o,
  output logic [SAMPLE_BITS-1:0]      hi_tap_o
);

  localparam logic [COUNT_BITS-1:0] Idx = COUNT_BITS'(INDEX);

  logic [SAMPLE_BITS-1:0] val_q, val_d;
  logic                   occupied;
  logic [COUNT_BITS-1:0]  half;
  logic                   hi_sel, lo_sel;

  assign occupied = Idx < count_i;
  // strictly below the new sample: stays put (new sample lands before equals)
  assign lt_o     = occupied && ($signed(val_q) < $signed(sample_i));

  assign half   = count_i >> 1;
  assign hi_sel = Idx == half;
  assign lo_sel = count_i[0] ? hi_sel : (Idx == (half - COUNT_BITS'(1)));

  assign lo_tap_o = lo_sel ? val_q : '0;
  assign hi_tap_o = hi_sel ? val_q : '0;
  assign val_o    = val_q;

  always_comb begin
    val_d = val_q;
    if (ins_i && !lt_o) begin
      val_d = left_lt_i ? sample_i : left_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

`default_nettype wire

// ===== sv/rms_tree.sv =====
// Registered OR-reduction tree that picks the two middle taps out of the cell row.
// Depends on rms_pkg.
`default_nettype none

module rms_tree
  import rms_pkg::*;
#(
  parameter int unsigned CAPACITY    = RMS_CAPACITY,
  parameter int unsigned SAMPLE_BITS = RMS_SAMPLE_BITS
) (
  input  wire logic                   clk_i,
  input  wire logic [SAMPLE_BITS-1:0] lo_leaf_i [CAPACITY],
  input  wire logic [SAMPLE_BITS-1:0] hi_leaf_i [CAPACITY],
  output logic [SAMPLE_BITS-1:0]      lo_root_o,
  output logic [SAMPLE_BITS-1:0]      hi_root_o
);

  localparam int unsigned Levels = $clog2(CAPACITY);
  localparam int unsigned Leaves = 1 << Levels;

  // heap layout: node 1 is the root, nodes Leaves..2*Leaves-1 are the leaves
  logic [SAMPLE_BITS-1:0] lo_q [1:2*Leaves-1];
  logic [SAMPLE_BITS-1:0] hi_q [1:2*Leaves-1];

  for (genvar k = 1; k < 2 * Leaves; k++) begin : g_node
    if (k >= Leaves) begin : g_leaf
      if ((k - Leaves) < CAPACITY) begin : g_used
        always_ff @(posedge clk_i) begin
          lo_q[k] <= lo_leaf_i[k - Leaves];
          hi_q[k] <= hi_leaf_i[k - Leaves];
        end
      end else begin : g_pad
        always_ff @(posedge clk_i) begin
          lo_q[k] <= '0;
          hi_q[k] <= '0;
        end
      end
    end else begin : g_inner
      always_ff @(posedge clk_i) begin
        lo_q[k] <= lo_q[2*k] | lo_q[2*k+1];
        hi_q[k] <= hi_q[2*k] | hi_q[2*k+1];
      end
    end
  end

  assign lo_root_o = lo_q[1];
  assign hi_root_o = hi_q[1];

endmodule

`default_nettype wire

// ===== sv/running_median_sorted_insert.sv =====
// Top level of the running median block: cell row, select tree, result register.
// Depends on rms_pkg, rms_in_if, rms_out_if, rms_cell, rms_tree.
//
//   port    | dir | modport | carries
//   --------+-----+---------+-----------------------------------------------
//   in_i    | in  | sink    | sample (signed)
//   out_o   | out | source  | median_doubled (signed), stored_count, rejected
//
// Steps: an item is accepted and inserted into the cell row on that edge, then
//   the middle entries climb the registered select tree to its root and are
//   loaded into the result register.
// Throughput: one item is in flight; the next item is accepted only once the
//   result register has taken the previous item's root value.
// Reset: clears the fill count, the in-flight tracking and the result valid;
//   cell contents are not reset (only cells below the fill count are ever used).
// Stalls: a result held on out_o does not block the next item; the next
//   result waits at the tree root until out_o is free.
`default_nettype none

module running_median_sorted_insert
  import rms_pkg::*;
#(
  parameter int unsigned CAPACITY    = RMS_CAPACITY,
  parameter int unsigned SAMPLE_BITS = RMS_SAMPLE_BITS
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rms_in_if.sink     in_i,
  rms_out_if.source  out_o
);

  localparam int unsigned CountBits = $clog2(CAPACITY + 1);
  localparam int unsigned Levels    = $clog2(CAPACITY);
  // stage 0: cells written, stage 1: leaves, stage Levels+1: root (sticky)
  localparam int unsigned VldTop    = Levels + 1;

  // ---------------------------------------------------------------------
  // Handshake and fill count
  // ---------------------------------------------------------------------
  logic                   in_fire, out_fire, full, ins;
  logic [CountBits-1:0]   count_q;
  logic [VldTop:0]        vld_q, vld_d;
  logic                   load;
  logic                   rej_q;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;
  assign full     = count_q == CountBits'(CAPACITY);
  assign ins      = in_fire && !full;   // full store: sample dropped, cells hold

  // busy while any stage of the single in-flight item is occupied
  assign in_i.ready = ~|vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ins) begin
      count_q <= count_q + CountBits'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rej_q <= full;
    end
  end

  // ---------------------------------------------------------------------
  // Cell row: each cell keeps, takes the sample, or takes its left neighbor
  // ---------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] cell_val [CAPACITY];
  logic                   cell_lt  [CAPACITY];
  logic [SAMPLE_BITS-1:0] lo_tap   [CAPACITY];
  logic [SAMPLE_BITS-1:0] hi_tap   [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                   left_lt;
    logic [SAMPLE_BITS-1:0] left_val;

    if (i == 0) begin : g_head
      // nothing to the left: the head cell takes the sample unless it stays
      assign left_lt  = 1'b1;
      assign left_val = in_i.sample;
    end else begin : g_body
      assign left_lt  = cell_lt[i-1];
      assign left_val = cell_val[i-1];
    end

    rms_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (CountBits),
      .INDEX       (i)
    ) u_cell (
      .clk_i      (clk_i),
      .ins_i      (ins),
      .sample_i   (in_i.sample),
      .count_i    (count_q),
      .left_lt_i  (left_lt),
      .left_val_i (left_val),
      .lt_o       (cell_lt[i]),
      .val_o      (cell_val[i]),
      .lo_tap_o   (lo_tap[i]),
      .hi_tap_o   (hi_tap[i])
    );
  end

  // ---------------------------------------------------------------------
  // Middle-entry select tree. The cells and count are frozen while an item
  // is in flight, so the free-running tree settles on the right pair.
  // ---------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] lo_root, hi_root;

  rms_tree #(
    .CAPACITY    (CAPACITY),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_tree (
    .clk_i     (clk_i),
    .lo_leaf_i (lo_tap),
    .hi_leaf_i (hi_tap),
    .lo_root_o (lo_root),
    .hi_root_o (hi_root)
  );

  // ---------------------------------------------------------------------
  // Stage tracking and result register
  // ---------------------------------------------------------------------
  logic                   out_valid_q;
  logic [SAMPLE_BITS:0]   median_q;
  logic [CountBits-1:0]   count_out_q;
  logic                   rej_out_q;

  assign load = vld_q[VldTop] && (!out_valid_q || out_o.ready);

  always_comb begin
    vld_d    = vld_q << 1;
    vld_d[0] = in_fire;
    // root stage holds until the result register takes it
    vld_d[VldTop] = vld_q[VldTop-1] || (vld_q[VldTop] && !load);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // odd count: both roots hold the middle entry, so the sum is twice it
  always_ff @(posedge clk_i) begin
    if (load) begin
      median_q    <= {lo_root[SAMPLE_BITS-1], lo_root} + {hi_root[SAMPLE_BITS-1], hi_root};
      count_out_q <= count_q;
      rej_out_q   <= rej_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.median_doubled = median_q;
  assign out_o.stored_count   = count_out_q;
  assign out_o.rejected       = rej_out_q;

endmodule

`default_nettype wire

// ===== sv/rms_checker.sv =====
// Port-level checks for the running median block, bound to the top level.
// Depends on rms_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rms_checker
  import rms_pkg::*;
#(
  parameter int unsigned CAPACITY    = RMS_CAPACITY,
  parameter int unsigned SAMPLE_BITS = RMS_SAMPLE_BITS
) (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_ready_i,
  input wire logic                              out_valid_i,
  input wire logic                              out_ready_i,
  input wire logic [SAMPLE_BITS:0]              median_i,
  input wire logic [$clog2(CAPACITY+1)-1:0]     count_i,
  input wire logic                              rejected_i
);

  localparam int unsigned CountBits = $clog2(CAPACITY + 1);
  localparam logic [CountBits-1:0] Cap = CountBits'(CAPACITY);

  `RMS_ASSERT_ALWAYS(a_no_result_in_reset, clk_i, !rst_ni |-> !out_valid_i, "result valid during reset")
  `RMS_ASSERT(a_one_in_flight, clk_i, rst_ni, (in_valid_i && in_ready_i) |=> !in_ready_i, "accepted a second item while busy")
  `RMS_ASSERT(a_reject_when_full, clk_i, rst_ni, (out_valid_i && rejected_i) |-> (count_i == Cap), "reject flagged below capacity")
  `RMS_ASSERT(a_count_range, clk_i, rst_ni, out_valid_i |-> (count_i != '0 && count_i <= Cap), "stored count out of range")
  `RMS_ASSERT(a_result_holds, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(median_i) && $stable(count_i)), "stalled result changed")

endmodule

bind running_median_sorted_insert rms_checker #(
  .CAPACITY    (CAPACITY),
  .SAMPLE_BITS (SAMPLE_BITS)
) u_rms_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .median_i    (out_o.median_doubled),
  .count_i     (out_o.stored_count),
  .rejected_i  (out_o.rejected)
);

`default_nettype wire

// ===== verif/running_median_sorted_insert_test.sv =====
// Testbench for running_median_sorted_insert: drives samples, predicts the doubled
// median with a sorted queue, and checks every result item in order.
// Depends on rms_pkg, rms_in_if, rms_out_if and the block itself.
`timescale 1ns / 100ps

module running_median_sorted_insert_test;
  import rms_pkg::*;

  localparam int unsigned SB = RMS_SAMPLE_BITS;
  localparam int unsigned CB = RMS_COUNT_BITS;
  // One item in flight: accept, insert, climb the select tree, load the result.
  localparam int unsigned ITEM_CYCLES = $clog2(RMS_CAPACITY) + 3;
  // Cycles without any accepted item before the run is declared hung.
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef enum int {
    NO_IDLE,
    SENDER_IDLE,
    RECEIVER_STALL,
    BOTH_IDLE
  } idling_e;

  typedef struct packed {
    logic [SB:0]   median_doubled;
    logic [CB-1:0] stored_count;
    logic          rejected;
  } median_result_t;

  logic clk;
  logic rst_n;

  rms_in_if  #(.SAMPLE_BITS(SB)) smp_if ();
  rms_out_if #(.SAMPLE_BITS(SB), .COUNT_BITS(CB)) med_if ();

  running_median_sorted_insert #(
    .CAPACITY    (RMS_CAPACITY),
    .SAMPLE_BITS (SB)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (smp_if),
    .out_o  (med_if)
  );

  // Predictor state: every stored (not rejected) sample, kept ascending.
  logic signed [SB-1:0] held_samples[$];
  // Results predicted but not yet seen on the output channel.
  median_result_t       pending_results[$];

  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned error_count;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Everything the block reads is known from time zero.
  initial begin
    smp_if.valid       = 1'b0;
    smp_if.sample      = '0;
    med_if.ready       = 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    error_count        = 0;
    mismatch_count     = 0;
    quiet_cycles       = 0;
  end

  // Insert a sample into the predictor's store (before equal entries) and
  // return the result item the block owes for it. A full store drops the
  // sample and reports the unchanged median with the reject flag set.
  function automatic median_result_t insert_and_median(input logic [SB-1:0] raw);
    logic signed [SB-1:0] s;
    logic signed [SB-1:0] lo;
    logic signed [SB-1:0] hi;
    int                   pos;
    int                   n;
    median_result_t       r;
    s = raw;
    r.rejected = 1'b0;
    if (held_samples.size() >= RMS_CAPACITY) begin
      r.rejected = 1'b1;
    end else begin
      pos = 0;
      while (pos < held_samples.size() && held_samples[pos] < s) pos++;
      held_samples.insert(pos, s);
    end
    n = held_samples.size();
    if (n == 0) begin
      r.median_doubled = '0;
    end else begin
      hi = held_samples[n / 2];
      lo = n[0] ? hi : held_samples[n / 2 - 1];
      // Sign-extend both middles to SB+1 bits; the sum is exact.
      r.median_doubled = {lo[SB-1], lo} + {hi[SB-1], hi};
    end
    r.stored_count = n[CB-1:0];
    return r;
  endfunction

  task automatic set_idling(input idling_e mode);
    case (mode)
      NO_IDLE: begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
      end
      SENDER_IDLE: begin
        sender_idle_pct    = 63;
        receiver_stall_pct = 0;
      end
      RECEIVER_STALL: begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 63;
      end
      default: begin
        sender_idle_pct    = 24;
        receiver_stall_pct = 24;
      end
    endcase
  endtask

  // Send one sample item. Called at a rising edge; returns at the edge where
  // the item is accepted, with the prediction already queued. valid only
  // drops when an idle gap is taken, so it is never lowered and raised in
  // the same time step.
  task automatic send_sample(input logic [SB-1:0] s);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      smp_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    smp_if.valid  <= 1'b1;
    smp_if.sample <= s;
    // ready is settled by the falling edge; sampling there avoids any race
    // with the block's own updates at the rising edge.
    @(negedge clk);
    while (!smp_if.ready) @(negedge clk);
    @(posedge clk);
    pending_results.insert(pending_results.size(), insert_and_median(s));
  endtask

  // Extremes of the sample range, alternating bit patterns, and runs of
  // equal samples (new one goes before the equal ones already held).
  task automatic test_extremes_and_ties();
    set_idling(NO_IDLE);
    send_sample(16'h0000);
    send_sample(16'h7fff);
    send_sample(16'h8000);
    send_sample(16'hffff);
    send_sample(16'h0001);
    send_sample(16'h5555);
    send_sample(16'haaaa);
    send_sample(16'h0007);
    send_sample(16'h0007);
    send_sample(16'h0007);
    send_sample(16'h8000);
    send_sample(16'h7fff);
  endtask

  // Random samples until the store is full. A good share repeats a value
  // already held or hits a range limit, so ties and edge compares stay common.
  task automatic test_fill_to_capacity();
    logic [SB-1:0] s;
    int            k;
    k = 0;
    while (held_samples.size() < RMS_CAPACITY) begin
      if (k % 13 == 0) set_idling(idling_e'((k / 13) % 4));
      case ($urandom_range(9))
        0, 1, 2: s = held_samples[$urandom_range(held_samples.size() - 1)];
        3:       s = held_samples[$urandom_range(held_samples.size() - 1)] + 1'b1;
        4:       s = $urandom_range(1) ? 16'h7fff : 16'h8000;
        default: s = SB'($urandom_range(16'hffff));
      endcase
      send_sample(s);
      k++;
    end
  endtask

  // Store full: every sample is dropped and flagged, median stays put.
  task automatic test_full_store();
    set_idling(BOTH_IDLE);
    send_sample(16'h0000);
    send_sample(16'h7fff);
    send_sample(16'h8000);
    send_sample(16'hffff);
    send_sample(held_samples[RMS_CAPACITY / 2]);
  endtask

  // Long random stream through each idling pattern in turn.
  task automatic test_random_stream();
    for (int p = 0; p < 4; p++) begin
      set_idling(idling_e'(p));
      repeat (345) send_sample(SB'($urandom_range(16'hffff)));
    end
  endtask

  // Output side: ready follows the current stall pattern, one update per edge.
  always @(posedge clk) begin
    med_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Result check and watchdog. Both sides are sampled at the falling edge,
  // where valid and ready are stable until the accepting rising edge.
  always @(negedge clk) begin
    median_result_t got;
    median_result_t want;
    if (rst_n) begin
      if (med_if.valid && med_if.ready) begin
        got.median_doubled = med_if.median_doubled;
        got.stored_count   = med_if.stored_count;
        got.rejected       = med_if.rejected;
        if (pending_results.size() == 0) begin
          error_count++;
          if (mismatch_count < REPORT_LIMIT)
            $display("%0t: result item with nothing expected: median2=%0d count=%0d rej=%0b",
                     $realtime, $signed(got.median_doubled), got.stored_count,
                     got.rejected);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.median_doubled !== want.median_doubled ||
              got.stored_count !== want.stored_count ||
              got.rejected !== want.rejected) begin
            error_count++;
            if (mismatch_count < REPORT_LIMIT)
              $display({"%0t: mismatch: median2 exp %0d got %0d, ",
                        "count exp %0d got %0d, rej exp %0b got %0b"},
                       $realtime, $signed(want.median_doubled),
                       $signed(got.median_doubled), want.stored_count,
                       got.stored_count, want.rejected, got.rejected);
            mismatch_count++;
          end
        end
      end
    end
    if ((smp_if.valid && smp_if.ready) || (med_if.valid && med_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL running_median_sorted_insert");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes_and_ties();
    test_fill_to_capacity();
    test_full_store();
    test_random_stream();
    smp_if.valid <= 1'b0;

    // Drain, then keep running idle so that any spurious result item would show.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3 * ITEM_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) error_count++;

    if (error_count == 0) begin
      $display("PASS running_median_sorted_insert");
    end else begin
      $display("FAIL running_median_sorted_insert");
    end
    $finish;
  end

endmodule
